[design/vfp_pkg.sv]
// ----------------------------------------------------------------------------
// Vsync frame pacer package
// Shared widths, timing constants, helpers and sequencer states.
// ----------------------------------------------------------------------------
package vfp_pkg;

	localparam longint TICKS_PER_SECOND = 1000000;

	localparam int TALLY_W = 16;
	localparam int RATE_W  = 24;
	localparam int SKIP_W  = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;
	localparam int NUM_W   = 56;
	localparam int QCNT_W  = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_PERIOD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAL_MODE     = 2'd3;

	localparam logic [1:0] RATE_VSYNC = 2'd0;
	localparam logic [1:0] RATE_FRAME = 2'd1;
	localparam logic [1:0] RATE_SHOWN = 2'd2;

	localparam logic [31:0] WINDOW_TICKS = 32'(TICKS_PER_SECOND);
	localparam logic [NUM_W-1:0] RATE_SCALE = NUM_W'(100 * TICKS_PER_SECOND);
	localparam logic [31:0] STEP_RESET = 32'(TICKS_PER_SECOND / 1000);
	localparam longint STEP_INC_VAL = (TICKS_PER_SECOND > 1000) ?
		TICKS_PER_SECOND / 5000 : TICKS_PER_SECOND / 1000;
	localparam logic signed [32:0] STEP_INC = 33'(STEP_INC_VAL);

	localparam longint NTSC_TARGET = 6000;
	localparam longint PAL_TARGET  = 5000;
	localparam logic [RATE_W-1:0] NTSC_HI = RATE_W'(NTSC_TARGET + NTSC_TARGET * 5 / 100);
	localparam logic [RATE_W-1:0] NTSC_LO = RATE_W'(NTSC_TARGET - NTSC_TARGET * 5 / 100);
	localparam logic [RATE_W-1:0] PAL_HI  = RATE_W'(PAL_TARGET + PAL_TARGET * 5 / 100);
	localparam logic [RATE_W-1:0] PAL_LO  = RATE_W'(PAL_TARGET - PAL_TARGET * 5 / 100);

	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_OVF,
		S_DIV,
		S_STEP,
		S_DELAY,
		S_OUT
	} state_t;

	function automatic logic signed [31:0] clamp33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [TALLY_W-1:0] tally_up(input logic [TALLY_W-1:0] t);
		return (t == {TALLY_W{1'b1}}) ? t : t + TALLY_W'(1);
	endfunction

endpackage

[design/vsync_frame_pacer_top.sv]
// ----------------------------------------------------------------------------
// Vsync frame pacer
// Field toggle, frame-skip pattern, one-second rate window and pacing delay.
// ----------------------------------------------------------------------------
// An item without a window close goes from acceptance straight to the output
// load. An item that closes the measurement window first computes the three
// rates in turn: one multiply by the constant rate scale, one overflow
// compare and 24 restoring-division steps on the one shared 33-bit
// subtractor. A rate that saturates skips its division. After the rates come
// the step update, the delay update when limiting adjusts, and the output
// load. in_stall stays high from acceptance until the result is loaded into
// the output register; a result waiting there does not block the next item,
// but a full and stalled output register holds the following result and the
// input with it.
module vsync_frame_pacer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vfp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   timestamp,
	input  logic                          transfer_busy,
	input  logic                          display_off,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          field_odd,
	output logic                          counted,
	output logic                          show_frame,
	output logic signed [31:0]            delay_ticks,
	output logic                          rates_valid,
	output logic [vfp_pkg::RATE_W-1:0]    vsync_rate,
	output logic [vfp_pkg::RATE_W-1:0]    frame_rate,
	output logic [vfp_pkg::RATE_W-1:0]    shown_rate
);

	logic [vfp_pkg::SKIP_W-1:0] skip_count_q, skip_period_q;
	logic limit_enable_q, pal_mode_q;

	logic odd_field_q;
	logic [vfp_pkg::TALLY_W-1:0] vsync_tally_q, frame_tally_q, shown_tally_q;
	logic skip_now_q;
	logic [vfp_pkg::SKIP_W-1:0] skip_left_q, period_left_q;
	logic signed [31:0] pace_delay_q, pace_step_q;
	logic [31:0] window_start_q;
	logic [vfp_pkg::RATE_W-1:0] rate_q [3];

	vfp_pkg::state_t state_q, state_d;

	logic res_counted_q, res_show_q, res_valid_q;
	logic signed [31:0] res_delay_q;
	logic [31:0] elapsed_q;
	logic [1:0] idx_q;
	logic [vfp_pkg::NUM_W-1:0] num_q;
	logic [31:0] rem_q;
	logic [vfp_pkg::RATE_W-1:0] quo_q;
	logic [vfp_pkg::QCNT_W-1:0] cnt_q;

	logic out_valid_q, field_odd_q, counted_q, show_q, rates_valid_q;
	logic signed [31:0] delay_q;

	logic accept;
	logic closing;
	logic ev_counted;
	logic [31:0] elapsed;
	logic [vfp_pkg::SKIP_W-1:0] cap;
	logic [vfp_pkg::TALLY_W-1:0] tally_sel;
	logic [vfp_pkg::NUM_W-1:0] product;
	logic ovf;
	logic [32:0] trial;
	logic trial_ge;
	logic last_bit;
	logic last_rate;
	logic out_load;
	logic [vfp_pkg::RATE_W-1:0] hi_thr, lo_thr;
	logic too_high, too_low, do_adjust;
	logic signed [32:0] step_wide, delay_wide;

	assign accept     = in_valid && !in_stall;
	assign ev_counted = !transfer_busy && !display_off;
	assign elapsed    = timestamp - window_start_q;
	assign closing    = ev_counted && (elapsed >= vfp_pkg::WINDOW_TICKS);
	assign cap        = (skip_period_q != '0) ? skip_period_q - vfp_pkg::SKIP_W'(1) : '0;

	always_comb begin
		case (idx_q)
			vfp_pkg::RATE_VSYNC: tally_sel = vsync_tally_q;
			vfp_pkg::RATE_FRAME: tally_sel = frame_tally_q;
			default:             tally_sel = shown_tally_q;
		endcase
	end

	assign product   = vfp_pkg::NUM_W'(tally_sel) * vfp_pkg::RATE_SCALE;
	assign ovf       = num_q[vfp_pkg::NUM_W-1 -: 32] >= elapsed_q;
	assign trial     = {rem_q, quo_q[vfp_pkg::RATE_W-1]};
	assign trial_ge  = trial >= {1'b0, elapsed_q};
	assign last_bit  = cnt_q == vfp_pkg::QCNT_W'(vfp_pkg::RATE_W - 1);
	assign last_rate = idx_q == vfp_pkg::RATE_SHOWN;
	assign out_load  = (state_q == vfp_pkg::S_OUT) && (!out_valid_q || !out_stall);

	assign hi_thr    = pal_mode_q ? vfp_pkg::PAL_HI : vfp_pkg::NTSC_HI;
	assign lo_thr    = pal_mode_q ? vfp_pkg::PAL_LO : vfp_pkg::NTSC_LO;
	assign too_high  = rate_q[0] > hi_thr;
	assign too_low   = rate_q[0] < lo_thr;
	assign do_adjust = limit_enable_q && (rate_q[1] != '0) && (too_high || too_low);

	always_comb begin
		if (too_high) begin
			step_wide = (!pace_step_q[31] && pace_step_q != '0) ?
				33'(pace_step_q) + vfp_pkg::STEP_INC : -33'(pace_step_q);
		end else begin
			step_wide = pace_step_q[31] ?
				33'(pace_step_q) - vfp_pkg::STEP_INC : -33'(pace_step_q);
		end
	end

	assign delay_wide = 33'(pace_delay_q) + 33'(pace_step_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vfp_pkg::S_IDLE:  if (accept) state_d = closing ? vfp_pkg::S_MUL : vfp_pkg::S_OUT;
			vfp_pkg::S_MUL:   state_d = vfp_pkg::S_OVF;
			vfp_pkg::S_OVF: begin
				if (!ovf) state_d = vfp_pkg::S_DIV;
				else if (last_rate) state_d = vfp_pkg::S_STEP;
				else state_d = vfp_pkg::S_MUL;
			end
			vfp_pkg::S_DIV: begin
				if (last_bit) state_d = last_rate ? vfp_pkg::S_STEP : vfp_pkg::S_MUL;
			end
			vfp_pkg::S_STEP:  state_d = do_adjust ? vfp_pkg::S_DELAY : vfp_pkg::S_OUT;
			vfp_pkg::S_DELAY: state_d = vfp_pkg::S_OUT;
			vfp_pkg::S_OUT:   if (out_load) state_d = vfp_pkg::S_IDLE;
			default:          state_d = vfp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != vfp_pkg::S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_count_q   <= '0;
			skip_period_q  <= '0;
			limit_enable_q <= 1'b0;
			pal_mode_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vfp_pkg::CFG_SKIP_COUNT:   skip_count_q   <= cfg_data;
				vfp_pkg::CFG_SKIP_PERIOD:  skip_period_q  <= cfg_data;
				vfp_pkg::CFG_LIMIT_ENABLE: limit_enable_q <= cfg_data[0];
				vfp_pkg::CFG_PAL_MODE:     pal_mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_field_q    <= 1'b0;
			vsync_tally_q  <= '0;
			frame_tally_q  <= '0;
			shown_tally_q  <= '0;
			skip_now_q     <= 1'b0;
			skip_left_q    <= '0;
			period_left_q  <= '0;
			pace_delay_q   <= '0;
			pace_step_q    <= vfp_pkg::STEP_RESET;
			window_start_q <= '0;
			rate_q[0]      <= '0;
			rate_q[1]      <= '0;
			rate_q[2]      <= '0;
		end else begin
			if (accept) begin
				odd_field_q <= !odd_field_q;
				if (ev_counted) begin
					vsync_tally_q <= vfp_pkg::tally_up(vsync_tally_q);
					frame_tally_q <= vfp_pkg::tally_up(frame_tally_q);
					if (!skip_now_q) shown_tally_q <= vfp_pkg::tally_up(shown_tally_q);
					skip_now_q <= skip_left_q != '0;
					if (period_left_q <= vfp_pkg::SKIP_W'(1)) begin
						skip_left_q   <= (skip_count_q < cap) ? skip_count_q : cap;
						period_left_q <= skip_period_q;
					end else begin
						if (skip_left_q != '0) skip_left_q <= skip_left_q - vfp_pkg::SKIP_W'(1);
						period_left_q <= period_left_q - vfp_pkg::SKIP_W'(1);
					end
					if (closing) window_start_q <= timestamp;
				end
			end
			if (state_q == vfp_pkg::S_OVF && ovf) rate_q[idx_q] <= vfp_pkg::RATE_MAX;
			if (state_q == vfp_pkg::S_DIV && last_bit) begin
				rate_q[idx_q] <= {quo_q[vfp_pkg::RATE_W-2:0], trial_ge};
			end
			if (state_q == vfp_pkg::S_STEP) begin
				vsync_tally_q <= '0;
				frame_tally_q <= '0;
				shown_tally_q <= '0;
				if (do_adjust) pace_step_q <= vfp_pkg::clamp33(step_wide);
			end
			if (state_q == vfp_pkg::S_DELAY) pace_delay_q <= vfp_pkg::clamp33(delay_wide);
		end
	end

	// shared multiply and divide datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) idx_q <= vfp_pkg::RATE_VSYNC;
			if (state_q == vfp_pkg::S_OVF) begin
				cnt_q <= '0;
				if (ovf) idx_q <= idx_q + 2'd1;
			end
			if (state_q == vfp_pkg::S_DIV) begin
				cnt_q <= cnt_q + vfp_pkg::QCNT_W'(1);
				if (last_bit) idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_counted_q <= ev_counted;
			res_show_q    <= ev_counted && !skip_now_q;
			res_delay_q   <= ev_counted ? pace_delay_q : '0;
			res_valid_q   <= closing;
			elapsed_q     <= elapsed;
		end
		if (state_q == vfp_pkg::S_MUL) num_q <= product;
		if (state_q == vfp_pkg::S_OVF) begin
			rem_q <= num_q[vfp_pkg::NUM_W-1 -: 32];
			quo_q <= num_q[vfp_pkg::RATE_W-1:0];
		end
		if (state_q == vfp_pkg::S_DIV) begin
			rem_q <= trial_ge ? 32'(trial - {1'b0, elapsed_q}) : trial[31:0];
			quo_q <= {quo_q[vfp_pkg::RATE_W-2:0], trial_ge};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			field_odd_q   <= odd_field_q;
			counted_q     <= res_counted_q;
			show_q        <= res_show_q;
			delay_q       <= res_delay_q;
			rates_valid_q <= res_valid_q;
			vsync_rate    <= rate_q[0];
			frame_rate    <= rate_q[1];
			shown_rate    <= rate_q[2];
		end
	end

	assign out_valid   = out_valid_q;
	assign field_odd   = field_odd_q;
	assign counted     = counted_q;
	assign show_frame  = show_q;
	assign delay_ticks = delay_q;
	assign rates_valid = rates_valid_q;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Vsync frame pacer testbench
// Drives vsync items through the valid/stall handshake with random idle
// bursts on both sides. An item-level predictor mirrors the field toggle,
// the skip pattern, the one-second rate window and the pacing delay, and
// every result is compared field by field. Directed items cover uncounted
// events, window edges and timer wrap; random segments run frame streams
// at varied rates or random timestamps under random register settings.
// The last part runs with no idling and limiting on, first at one vsync
// per second and then well above the target rate.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint TPS = vfp_pkg::TICKS_PER_SECOND;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int RAND_ITEMS = 1000;
	localparam int SLOW_ITEMS = 200;
	localparam int FAST_ITEMS = 150;

	typedef struct {
		logic [31:0] ts;
		logic        busy;
		logic        off;
	} vsync_evt_t;

	typedef struct {
		logic                       field_odd;
		logic                       counted;
		logic                       show_frame;
		logic signed [31:0]         delay_ticks;
		logic                       rates_valid;
		logic [vfp_pkg::RATE_W-1:0] vsync_rate;
		logic [vfp_pkg::RATE_W-1:0] frame_rate;
		logic [vfp_pkg::RATE_W-1:0] shown_rate;
	} pace_res_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [vfp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [vfp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [31:0]                    timestamp = '0;
	logic                           transfer_busy = 1'b0;
	logic                           display_off = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           field_odd;
	logic                           counted;
	logic                           show_frame;
	logic signed [31:0]             delay_ticks;
	logic                           rates_valid;
	logic [vfp_pkg::RATE_W-1:0]     vsync_rate;
	logic [vfp_pkg::RATE_W-1:0]     frame_rate;
	logic [vfp_pkg::RATE_W-1:0]     shown_rate;

	vsync_frame_pacer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.timestamp(timestamp),
		.transfer_busy(transfer_busy),
		.display_off(display_off),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.field_odd(field_odd),
		.counted(counted),
		.show_frame(show_frame),
		.delay_ticks(delay_ticks),
		.rates_valid(rates_valid),
		.vsync_rate(vsync_rate),
		.frame_rate(frame_rate),
		.shown_rate(shown_rate)
	);

	always #1 clk = ~clk;

	vsync_evt_t pending[$];
	pace_res_t  expected_q[$];

	bit tx_loaded = 1'b0;
	bit idle_on = 1'b0;
	int rx_hold_req = 0;
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_closes = 0;
	int n_cfg = 0;
	int cycle_cnt = 0;

	logic [3:0] reg_skip_count = '0;
	logic [3:0] reg_skip_period = '0;
	logic       reg_limit = 1'b0;
	logic       reg_pal = 1'b0;

	logic                       odd_bit = 1'b0;
	logic [15:0]                vs_cnt = '0;
	logic [15:0]                fr_cnt = '0;
	logic [15:0]                sh_cnt = '0;
	logic                       skip_flag = 1'b0;
	logic [7:0]                 skip_rem = '0;
	logic [7:0]                 period_rem = '0;
	int                         delay_acc = 0;
	int                         step_acc = int'(TPS / 1000);
	logic [31:0]                win_start = '0;
	logic [vfp_pkg::RATE_W-1:0] rate_v = '0;
	logic [vfp_pkg::RATE_W-1:0] rate_f = '0;
	logic [vfp_pkg::RATE_W-1:0] rate_s = '0;

	function automatic logic [15:0] tally_inc(input logic [15:0] t);
		return (t == 16'hFFFF) ? t : t + 16'd1;
	endfunction

	function automatic logic [vfp_pkg::RATE_W-1:0] rate_calc(input logic [15:0] tally,
			input logic [31:0] span);
		longint unsigned q;
		q = (64'(tally) * 64'd100 * 64'(TPS)) / 64'(span);
		return (q > 64'(vfp_pkg::RATE_MAX)) ? vfp_pkg::RATE_MAX : q[vfp_pkg::RATE_W-1:0];
	endfunction

	function automatic int clamp_s32(input longint v);
		if (v > longint'(32'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		if (v < -longint'(64'sh8000_0000))
			return 32'sh8000_0000;
		return int'(v);
	endfunction

	task automatic pacer_predict(input vsync_evt_t ev, output pace_res_t r);
		logic [31:0] elapsed;
		logic [7:0]  cap;
		longint      st;
		longint      inc;
		longint      target;
		longint      band;
		logic        adjust;
		odd_bit = ~odd_bit;
		r.field_odd = odd_bit;
		r.counted = 1'b0;
		r.show_frame = 1'b0;
		r.delay_ticks = '0;
		r.rates_valid = 1'b0;
		if (!ev.busy && !ev.off) begin
			r.counted = 1'b1;
			vs_cnt = tally_inc(vs_cnt);
			fr_cnt = tally_inc(fr_cnt);
			r.show_frame = !skip_flag;
			if (r.show_frame)
				sh_cnt = tally_inc(sh_cnt);
			skip_flag = (skip_rem != 0);
			if (skip_rem != 0)
				skip_rem = skip_rem - 8'd1;
			if (period_rem <= 8'd1) begin
				cap = (reg_skip_period != 0) ? 8'(reg_skip_period) - 8'd1 : 8'd0;
				skip_rem = (8'(reg_skip_count) < cap) ? 8'(reg_skip_count) : cap;
				period_rem = 8'(reg_skip_period);
			end else begin
				period_rem = period_rem - 8'd1;
			end
			r.delay_ticks = delay_acc;
			elapsed = ev.ts - win_start;
			if (elapsed >= 32'(TPS)) begin
				rate_v = rate_calc(vs_cnt, elapsed);
				rate_f = rate_calc(fr_cnt, elapsed);
				rate_s = rate_calc(sh_cnt, elapsed);
				r.rates_valid = 1'b1;
				if (reg_limit && rate_f != 0) begin
					inc = (TPS > 1000) ? TPS / 5000 : TPS / 1000;
					target = reg_pal ? vfp_pkg::PAL_TARGET : vfp_pkg::NTSC_TARGET;
					band = target * 5 / 100;
					st = step_acc;
					adjust = 1'b0;
					if (longint'(rate_v) > target + band) begin
						st = (st > 0) ? st + inc : -st;
						adjust = 1'b1;
					end else if (longint'(rate_v) < target - band) begin
						st = (st < 0) ? st - inc : -st;
						adjust = 1'b1;
					end
					if (adjust) begin
						step_acc = clamp_s32(st);
						delay_acc = clamp_s32(longint'(delay_acc) + longint'(step_acc));
					end
				end
				vs_cnt = '0;
				fr_cnt = '0;
				sh_cnt = '0;
				win_start = ev.ts;
			end
		end
		r.vsync_rate = rate_v;
		r.frame_rate = rate_f;
		r.shown_rate = rate_s;
	endtask

	task automatic cmp_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			errors++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic set_reg(input logic [vfp_pkg::CFG_IDX_W-1:0] idx,
			input logic [vfp_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vfp_pkg::CFG_SKIP_COUNT: reg_skip_count = val[3:0];
			vfp_pkg::CFG_SKIP_PERIOD: reg_skip_period = val[3:0];
			vfp_pkg::CFG_LIMIT_ENABLE: reg_limit = val[0];
			vfp_pkg::CFG_PAL_MODE: reg_pal = val[0];
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || tx_loaded || expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drv
		pace_res_t  res;
		vsync_evt_t cur;
		int         tx_gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				pacer_predict(cur, res);
				expected_q.push_back(res);
				tx_loaded = 1'b0;
				n_items++;
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (idle_on && pending.size() != 0 && $urandom_range(0, 5) == 0) begin
					tx_gap = $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					cur = pending.pop_front();
					tx_loaded = 1'b1;
					timestamp <= cur.ts;
					transfer_busy <= cur.busy;
					display_off <= cur.off;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : mon
		pace_res_t want;
		int        rx_gap;
		int        rx_hold_left;
		int        rx_hold_seen;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap = 0;
			rx_hold_left = 0;
			rx_hold_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					errors++;
					$error("result with no item pending");
				end else begin
					want = expected_q.pop_front();
					n_results++;
					if (want.rates_valid)
						n_closes++;
					cmp_field("field_odd", want.field_odd, field_odd);
					cmp_field("counted", want.counted, counted);
					cmp_field("show_frame", want.show_frame, show_frame);
					cmp_field("delay_ticks", want.delay_ticks, delay_ticks);
					cmp_field("rates_valid", want.rates_valid, rates_valid);
					cmp_field("vsync_rate", want.vsync_rate, vsync_rate);
					cmp_field("frame_rate", want.frame_rate, frame_rate);
					cmp_field("shown_rate", want.shown_rate, shown_rate);
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_stall <= 1'b1;
			end else if (rx_hold_seen != rx_hold_req) begin
				rx_hold_seen = rx_hold_req;
				rx_hold_left = 299;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				rx_gap = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stim
		int          frame_len[8];
		int          n_rand;
		int          seg;
		int          per;
		int          nwin;
		int          tail;
		logic [31:0] ts_now;
		logic        b;
		logic        o;
		logic [3:0]  sc;
		logic [3:0]  sp;
		bit          hold_done;
		frame_len = '{16667, 20000, 14000, 19000, 17500, 22500, 18500, 15873};
		n_rand = 0;
		seg = 0;
		hold_done = 1'b0;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		idle_on = 1'b1;

		pending.push_back('{32'd0, 1'b0, 1'b0});
		pending.push_back('{32'd5, 1'b1, 1'b0});
		pending.push_back('{32'd6, 1'b0, 1'b1});
		pending.push_back('{32'd7, 1'b1, 1'b1});
		pending.push_back('{32'd999999, 1'b0, 1'b0});
		pending.push_back('{32'd1000000, 1'b0, 1'b0});
		pending.push_back('{32'hFFFF_FFFF, 1'b0, 1'b0});
		pending.push_back('{32'h0000_0010, 1'b0, 1'b0});
		wait_idle();

		set_reg(vfp_pkg::CFG_SKIP_COUNT, 4'd15);
		set_reg(vfp_pkg::CFG_SKIP_PERIOD, 4'd15);
		set_reg(vfp_pkg::CFG_LIMIT_ENABLE, 4'd1);
		set_reg(vfp_pkg::CFG_PAL_MODE, 4'd1);
		ts_now = 32'h10;
		for (int k = 0; k < 8; k++) begin
			ts_now = ts_now + 32'd1000000;
			pending.push_back('{ts_now, 1'b0, 1'b0});
		end
		pending.push_back('{ts_now, 1'b1, 1'b0});
		ts_now = ts_now + 32'h8000_0000;
		pending.push_back('{ts_now, 1'b0, 1'b0});
		wait_idle();

		set_reg(vfp_pkg::CFG_SKIP_PERIOD, 4'd1);
		set_reg(vfp_pkg::CFG_SKIP_COUNT, 4'd3);
		repeat (3) begin
			ts_now = ts_now + 32'd16667;
			pending.push_back('{ts_now, 1'b0, 1'b0});
		end
		wait_idle();
		set_reg(vfp_pkg::CFG_SKIP_PERIOD, 4'd0);
		set_reg(vfp_pkg::CFG_SKIP_COUNT, 4'd5);
		repeat (3) begin
			ts_now = ts_now + 32'd16667;
			pending.push_back('{ts_now, 1'b0, 1'b0});
		end

		while (n_rand < RAND_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 3))
				0: sc = 4'd0;
				1: sc = 4'd15;
				default: sc = 4'($urandom_range(0, 15));
			endcase
			case ($urandom_range(0, 3))
				0: sp = 4'd0;
				1: sp = 4'd15;
				default: sp = 4'($urandom_range(0, 15));
			endcase
			set_reg(vfp_pkg::CFG_SKIP_COUNT, sc);
			set_reg(vfp_pkg::CFG_SKIP_PERIOD, sp);
			set_reg(vfp_pkg::CFG_LIMIT_ENABLE, 4'($urandom_range(0, 15)));
			set_reg(vfp_pkg::CFG_PAL_MODE, 4'($urandom_range(0, 15)));
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 6) == 0) begin
				repeat (20) begin
					ts_now = $urandom;
					b = 1'($urandom_range(0, 1));
					o = 1'($urandom_range(0, 1));
					pending.push_back('{ts_now, b, o});
					n_rand++;
				end
			end else begin
				per = frame_len[$urandom_range(0, 7)];
				nwin = $urandom_range(1, 2);
				repeat (nwin * (1000000 / per + 2)) begin
					ts_now = ts_now + 32'(per - 200 + int'($urandom_range(0, 400)));
					b = ($urandom_range(0, 11) == 0);
					o = ($urandom_range(0, 11) == 0);
					pending.push_back('{ts_now, b, o});
					n_rand++;
				end
				if (!hold_done && seg >= 2) begin
					idle_on = 1'b1;
					rx_hold_req++;
					hold_done = 1'b1;
				end
			end
			seg++;
		end

		wait_idle();
		idle_on = 1'b0;
		set_reg(vfp_pkg::CFG_SKIP_COUNT, 4'd0);
		set_reg(vfp_pkg::CFG_SKIP_PERIOD, 4'd0);
		set_reg(vfp_pkg::CFG_LIMIT_ENABLE, 4'd1);
		set_reg(vfp_pkg::CFG_PAL_MODE, 4'd0);
		repeat (SLOW_ITEMS) begin
			ts_now = ts_now + 32'd1000000 + 32'($urandom_range(0, 5000));
			pending.push_back('{ts_now, 1'b0, 1'b0});
		end
		repeat (FAST_ITEMS) begin
			ts_now = ts_now + 32'd8000;
			pending.push_back('{ts_now, 1'b0, 1'b0});
		end
		ts_now = ts_now + 32'd1000000;
		pending.push_back('{ts_now, 1'b0, 1'b0});

		while (pending.size() != 0 || tx_loaded)
			@(posedge clk);
		tail = 0;
		while (expected_q.size() != 0 && tail < 2000) begin
			@(posedge clk);
			tail++;
		end
		repeat (100) @(posedge clk);
		if (expected_q.size() != 0) begin
			errors++;
			$error("%0d expected results never arrived", expected_q.size());
		end

		$display("Run covered %0d vsync items, %0d results checked, %0d window closes,",
			n_items, n_results, n_closes);
		$display("%0d register writes, slow and fast rate limiting, %0d mismatches.",
			n_cfg, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
